// ----- design/multichannel_leaky_pid_macros.svh -----
// Assertion macros of the multichannel_leaky_pid top level
`ifndef MULTICHANNEL_LEAKY_PID_MACROS_SVH
`define MULTICHANNEL_LEAKY_PID_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define MLPID_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mlpid assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define MLPID_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mlpid assertion failed");

`endif

// ----- design/mlpid_pkg.sv -----
// Shared types and constants of the multichannel leaky PID controller
`timescale 1ns / 1ps

package mlpid_pkg;

    localparam int GAIN_REGS = 6;
    localparam int GAIN_W    = 48;
    localparam int IDX_W     = 3;
    localparam int CH_IN_W   = 3;
    localparam int ERR_W     = 16;
    localparam int LEAK_W    = 16;
    localparam int LIM_W     = 15;
    localparam int INTEG_W   = 32;
    localparam int DE_W      = 17;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = 49;
    localparam int ACC_W     = 50;
    localparam int U_W       = 38;

    localparam logic [LEAK_W:0] ONE_Q15 = 17'd32768;

    // Per-step commands from the controller to the datapath
    typedef struct packed {
        logic latch;     // capture the input transfer
        logic sum;       // integral + error, derivative, store last error
        logic leak_mul;  // multiply sum by leak
        logic integ;     // round and store integral, start kp*e
        logic mul_ki;    // acc = kp*e, start ki*integral
        logic mul_kd;    // acc += ki*integral, start kd*de
        logic acc_last;  // acc += kd*de
        logic round;     // round acc to Q30.8
        logic load_out;  // clamp and load the result register
        logic zero_out;  // result is zero (channel out of range)
    } mlpid_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic chan_ok;   // offered channel is in range
    } mlpid_sts_t;

endpackage

// ----- design/mlpid_datapath.sv -----
// Datapath: gain registers, channel state, shared multiplier, accumulator and clamp
`timescale 1ns / 1ps

module mlpid_datapath #(
    parameter int CHANNELS = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [mlpid_pkg::IDX_W-1:0]           cfg_index,
    input  logic [mlpid_pkg::GAIN_W-1:0]          cfg_wdata,
    input  logic [mlpid_pkg::CH_IN_W-1:0]         s_channel,
    input  logic signed [mlpid_pkg::ERR_W-1:0]    s_error_in,
    input  logic [mlpid_pkg::LEAK_W-1:0]          s_leak,
    input  logic [mlpid_pkg::LIM_W-1:0]           s_limit,
    input  mlpid_pkg::mlpid_cmd_t                 cmd,
    output mlpid_pkg::mlpid_sts_t                 sts,
    output logic signed [mlpid_pkg::ERR_W-1:0]    m_drive,
    output logic                                  m_clamped
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [mlpid_pkg::CH_IN_W-1:0] CH_LIM = mlpid_pkg::CH_IN_W'(CHANNELS);
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_LIM = mlpid_pkg::IDX_W'(mlpid_pkg::GAIN_REGS);

    // Configuration and per-channel state
    logic [mlpid_pkg::GAIN_W-1:0]          gains_reg [mlpid_pkg::GAIN_REGS];
    logic signed [mlpid_pkg::INTEG_W-1:0]  integ_reg [CHANNELS];
    logic signed [mlpid_pkg::ERR_W-1:0]    lerr_reg  [CHANNELS];

    // Captured transfer
    logic [mlpid_pkg::CH_IN_W-1:0]         ch_reg;
    logic signed [mlpid_pkg::ERR_W-1:0]    err_reg;
    logic [mlpid_pkg::LEAK_W:0]            leak_reg;
    logic [mlpid_pkg::LIM_W-1:0]           lim_reg;

    // Working registers
    logic signed [mlpid_pkg::INTEG_W-1:0]  s_reg;
    logic signed [mlpid_pkg::DE_W-1:0]     de_reg;
    logic signed [mlpid_pkg::INTEG_W-1:0]  ig_reg;
    logic signed [mlpid_pkg::PROD_W-1:0]   prod_reg;
    logic signed [mlpid_pkg::ACC_W-1:0]    acc_reg;
    logic signed [mlpid_pkg::U_W-1:0]      u_reg;
    logic signed [mlpid_pkg::ERR_W-1:0]    drive_reg;
    logic                                  clamped_reg;

    logic [CH_W-1:0]                       ch_idx;
    logic [mlpid_pkg::GAIN_W-1:0]          gsel;
    logic [mlpid_pkg::ERR_W-1:0]           kp, ki, kd;
    logic signed [mlpid_pkg::INTEG_W:0]    sum_wide;
    logic signed [mlpid_pkg::INTEG_W-1:0]  sum_next;
    logic signed [mlpid_pkg::DE_W-1:0]     de_next;
    logic signed [mlpid_pkg::ACC_W-1:0]    ig_rnd;
    logic signed [mlpid_pkg::INTEG_W-1:0]  ig_next;
    logic signed [mlpid_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [mlpid_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [mlpid_pkg::MUL_A_W+mlpid_pkg::MUL_B_W-1:0] mul_full;
    logic signed [mlpid_pkg::ACC_W-1:0]    prod_ext;
    logic signed [mlpid_pkg::ACC_W-1:0]    acc_rnd;
    logic signed [mlpid_pkg::U_W-1:0]      lim_pos;
    logic signed [mlpid_pkg::U_W-1:0]      lim_neg;
    logic [mlpid_pkg::LEAK_W:0]            leak_sat;

    assign sts.chan_ok = (s_channel < CH_LIM);
    assign ch_idx      = ch_reg[CH_W-1:0];
    assign gsel        = gains_reg[ch_reg];
    assign kp          = gsel[47:32];
    assign ki          = gsel[31:16];
    assign kd          = gsel[15:0];
    assign leak_sat    = (s_leak > mlpid_pkg::ONE_Q15[mlpid_pkg::LEAK_W-1:0] && s_leak[15])
                         ? mlpid_pkg::ONE_Q15 : {1'b0, s_leak};

    // Gain register writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mlpid_pkg::GAIN_REGS; i++) begin
                gains_reg[i] <= '0;
            end
        end else if (cfg_wen && (cfg_index < REG_LIM)) begin
            gains_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Saturating integral + error, and derivative
    always_comb begin
        sum_wide = {integ_reg[ch_idx][mlpid_pkg::INTEG_W-1], integ_reg[ch_idx]}
                 + {{(mlpid_pkg::INTEG_W + 1 - mlpid_pkg::ERR_W){err_reg[mlpid_pkg::ERR_W-1]}},
                    err_reg};
        if (sum_wide[mlpid_pkg::INTEG_W] != sum_wide[mlpid_pkg::INTEG_W-1]) begin
            sum_next = sum_wide[mlpid_pkg::INTEG_W] ? {1'b1, {(mlpid_pkg::INTEG_W-1){1'b0}}}
                                                    : {1'b0, {(mlpid_pkg::INTEG_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[mlpid_pkg::INTEG_W-1:0];
        end
        de_next = {err_reg[mlpid_pkg::ERR_W-1], err_reg}
                - {lerr_reg[ch_idx][mlpid_pkg::ERR_W-1], lerr_reg[ch_idx]};
    end

    // Leaked integral: round half up by 2^15, saturate to 32 bits
    always_comb begin
        ig_rnd = {prod_reg[mlpid_pkg::PROD_W-1], prod_reg} + mlpid_pkg::ACC_W'(16384);
        if (ig_rnd[49:46] != {4{ig_rnd[49]}}) begin
            ig_next = ig_rnd[49] ? {1'b1, {(mlpid_pkg::INTEG_W-1){1'b0}}}
                                 : {1'b0, {(mlpid_pkg::INTEG_W-1){1'b1}}};
        end else begin
            ig_next = ig_rnd[46:15];
        end
    end

    // Shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.leak_mul) begin
            mul_a = {s_reg[mlpid_pkg::INTEG_W-1], s_reg};
            mul_b = {1'b0, leak_reg};
        end else if (cmd.integ) begin
            mul_a = {{(mlpid_pkg::MUL_A_W - mlpid_pkg::ERR_W){err_reg[mlpid_pkg::ERR_W-1]}},
                     err_reg};
            mul_b = {2'b00, kp};
        end else if (cmd.mul_ki) begin
            mul_a = {ig_reg[mlpid_pkg::INTEG_W-1], ig_reg};
            mul_b = {2'b00, ki};
        end else if (cmd.mul_kd) begin
            mul_a = {{(mlpid_pkg::MUL_A_W - mlpid_pkg::DE_W){de_reg[mlpid_pkg::DE_W-1]}},
                     de_reg};
            mul_b = {2'b00, kd};
        end
    end

    assign mul_full = mul_a * mul_b;
    assign prod_ext = {prod_reg[mlpid_pkg::PROD_W-1], prod_reg};
    assign acc_rnd  = acc_reg + mlpid_pkg::ACC_W'(2048);
    assign lim_pos  = {{(mlpid_pkg::U_W - mlpid_pkg::LIM_W){1'b0}}, lim_reg};
    assign lim_neg  = -lim_pos;

    // Capture the transfer
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            ch_reg   <= s_channel;
            err_reg  <= s_error_in;
            leak_reg <= leak_sat;
            lim_reg  <= s_limit;
        end
    end

    // Channel state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                integ_reg[i] <= '0;
                lerr_reg[i]  <= '0;
            end
        end else begin
            if (cmd.sum) begin
                lerr_reg[ch_idx] <= err_reg;
            end
            if (cmd.integ) begin
                integ_reg[ch_idx] <= ig_next;
            end
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            s_reg  <= sum_next;
            de_reg <= de_next;
        end
        if (cmd.integ) begin
            ig_reg <= ig_next;
        end
        if (cmd.leak_mul || cmd.integ || cmd.mul_ki || cmd.mul_kd) begin
            prod_reg <= mul_full[mlpid_pkg::PROD_W-1:0];
        end
        if (cmd.mul_ki) begin
            acc_reg <= prod_ext;
        end else if (cmd.mul_kd || cmd.acc_last) begin
            acc_reg <= acc_reg + prod_ext;
        end
        if (cmd.round) begin
            u_reg <= acc_rnd[mlpid_pkg::ACC_W-1:12];
        end
    end

    // Clamp into the result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (cmd.zero_out) begin
                drive_reg   <= '0;
                clamped_reg <= 1'b0;
            end else if (u_reg > lim_pos) begin
                drive_reg   <= lim_pos[mlpid_pkg::ERR_W-1:0];
                clamped_reg <= 1'b1;
            end else if (u_reg < lim_neg) begin
                drive_reg   <= lim_neg[mlpid_pkg::ERR_W-1:0];
                clamped_reg <= 1'b1;
            end else begin
                drive_reg   <= u_reg[mlpid_pkg::ERR_W-1:0];
                clamped_reg <= 1'b0;
            end
        end
    end

    assign m_drive   = drive_reg;
    assign m_clamped = clamped_reg;

endmodule

// ----- design/mlpid_ctrl.sv -----
// Controller: sequences one transfer through the datapath and owns the handshakes
`timescale 1ns / 1ps

module mlpid_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  mlpid_pkg::mlpid_sts_t sts,
    output mlpid_pkg::mlpid_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SUM  = 4'd1;
    localparam logic [3:0] ST_LEAK = 4'd2;
    localparam logic [3:0] ST_INTG = 4'd3;
    localparam logic [3:0] ST_MKI  = 4'd4;
    localparam logic [3:0] ST_MKD  = 4'd5;
    localparam logic [3:0] ST_ACC  = 4'd6;
    localparam logic [3:0] ST_RND  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       bad_reg, bad_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;
    logic       accept;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    // Next state and step commands
    always_comb begin
        state_next = state_reg;
        bad_next   = bad_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.latch  = 1'b1;
                    bad_next   = !sts.chan_ok;
                    state_next = sts.chan_ok ? ST_SUM : ST_OUT;
                end
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_LEAK;
            end
            ST_LEAK: begin
                cmd.leak_mul = 1'b1;
                state_next   = ST_INTG;
            end
            ST_INTG: begin
                cmd.integ  = 1'b1;
                state_next = ST_MKI;
            end
            ST_MKI: begin
                cmd.mul_ki = 1'b1;
                state_next = ST_MKD;
            end
            ST_MKD: begin
                cmd.mul_kd = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_last = 1'b1;
                state_next   = ST_RND;
            end
            ST_RND: begin
                cmd.round  = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.zero_out = bad_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when the transfer completes
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bad_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- design/multichannel_leaky_pid.sv -----
// Top level of the six-channel leaky PID controller
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    s_channel s_error_in s_leak s_limit
//  m_        out        m_valid/m_ready    m_drive m_clamped
//  cfg_      in         cfg_wen            cfg_index cfg_wdata (gain registers)
//
// An in-range transfer gives a valid result after its round and output steps; one
// 33x18 multiplier is shared by the leak, kp, ki and kd products in turn.
// An out-of-range channel goes straight to the output step and gives a zero result.
// A new transfer is accepted as soon as the result is loaded, even while it waits,
// so no new transfer is taken while one is still being sequenced. A stalled result holds
// the sequencer in its last step; reset clears control, gains and channel state.
`timescale 1ns / 1ps
`include "multichannel_leaky_pid_macros.svh"

module multichannel_leaky_pid #(
    parameter int CHANNELS = 6
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wen,
    input  logic [mlpid_pkg::IDX_W-1:0]           cfg_index,
    input  logic [mlpid_pkg::GAIN_W-1:0]          cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mlpid_pkg::CH_IN_W-1:0]         s_channel,
    input  logic signed [mlpid_pkg::ERR_W-1:0]    s_error_in,
    input  logic [mlpid_pkg::LEAK_W-1:0]          s_leak,
    input  logic [mlpid_pkg::LIM_W-1:0]           s_limit,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mlpid_pkg::ERR_W-1:0]    m_drive,
    output logic                                  m_clamped
);

    localparam logic [mlpid_pkg::CH_IN_W-1:0] CH_LIM = mlpid_pkg::CH_IN_W'(CHANNELS);

    mlpid_pkg::mlpid_cmd_t cmd;
    mlpid_pkg::mlpid_sts_t sts;

    logic in_xfer;
    logic fresh_xfer;
    logic good_xfer;
    logic bad_xfer;
    logic zero_result;

    // Sequencer
    mlpid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Arithmetic and state
    mlpid_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_channel  (s_channel),
        .s_error_in (s_error_in),
        .s_leak     (s_leak),
        .s_limit    (s_limit),
        .cmd        (cmd),
        .sts        (sts),
        .m_drive    (m_drive),
        .m_clamped  (m_clamped)
    );

    // Terms for the checks
    assign in_xfer     = s_valid && s_ready;
    assign fresh_xfer  = in_xfer && !m_valid;
    assign good_xfer   = fresh_xfer && (s_channel < CH_LIM);
    assign bad_xfer    = fresh_xfer && (s_channel >= CH_LIM);
    assign zero_result = m_valid && (m_drive == '0) && !m_clamped;

    // Checks
    `MLPID_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, in_xfer, !s_ready)
    `MLPID_ASSERT_NEXT(a_bad_channel_zero, aclk, aresetn, bad_xfer, ##1 zero_result)
    `MLPID_ASSERT_NEXT(a_result_latency, aclk, aresetn, good_xfer, ##7 (!m_valid) ##1 m_valid)

endmodule

// ----- dv/multichannel_leaky_pid_test.sv -----
// Self-checking testbench of the six-channel leaky PID controller
`timescale 1ns / 1ps

module multichannel_leaky_pid_test;

    localparam int CHANNELS       = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 12;

    // Register map: gains of channel N sit at index N, the top two are unused
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_GAINS_CH0 = 3'd0;
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_GAINS_CH1 = 3'd1;
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_GAINS_CH2 = 3'd2;
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_GAINS_CH3 = 3'd3;
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_GAINS_CH4 = 3'd4;
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_GAINS_CH5 = 3'd5;
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_UNUSED_6  = 3'd6;
    localparam logic [mlpid_pkg::IDX_W-1:0] REG_UNUSED_7  = 3'd7;

    localparam logic [15:0] GAIN_ONE = 16'h1000;  // 1.0 in Q4.12
    localparam logic [15:0] GAIN_MAX = 16'hFFFF;

    typedef struct {
        logic signed [mlpid_pkg::ERR_W-1:0] drive;
        logic                               clamped;
    } pid_result_t;

    logic                                aclk;
    logic                                aresetn    = 1'b0;
    logic                                cfg_wen    = 1'b0;
    logic [mlpid_pkg::IDX_W-1:0]         cfg_index  = '0;
    logic [mlpid_pkg::GAIN_W-1:0]        cfg_wdata  = '0;
    logic                                s_valid    = 1'b0;
    logic                                s_ready;
    logic [mlpid_pkg::CH_IN_W-1:0]       s_channel  = '0;
    logic signed [mlpid_pkg::ERR_W-1:0]  s_error_in = '0;
    logic [mlpid_pkg::LEAK_W-1:0]        s_leak     = '0;
    logic [mlpid_pkg::LIM_W-1:0]         s_limit    = '0;
    logic                                m_valid;
    logic                                m_ready    = 1'b0;
    logic signed [mlpid_pkg::ERR_W-1:0]  m_drive;
    logic                                m_clamped;

    // Shadow copy of the controller state and gain registers
    logic [mlpid_pkg::GAIN_W-1:0]        gains_shadow [CHANNELS];
    int                                  integral_shadow [CHANNELS];
    logic signed [mlpid_pkg::ERR_W-1:0]  last_error_shadow [CHANNELS];

    pid_result_t drive_expect_q[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          stall_left     = 0;
    bit          idle_on        = 1'b1;

    multichannel_leaky_pid #(.CHANNELS(CHANNELS)) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wen    (cfg_wen),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_channel  (s_channel),
        .s_error_in (s_error_in),
        .s_leak     (s_leak),
        .s_limit    (s_limit),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .m_clamped  (m_clamped)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        for (int i = 0; i < CHANNELS; i++) begin
            gains_shadow[i]      = '0;
            integral_shadow[i]   = 0;
            last_error_shadow[i] = '0;
        end
    end

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Controller update for one transfer: advances the shadow state, returns the output
    function automatic pid_result_t pid_update(input logic [mlpid_pkg::CH_IN_W-1:0] ch,
                                               input logic signed [mlpid_pkg::ERR_W-1:0] err,
                                               input logic [mlpid_pkg::LEAK_W-1:0] leak_in,
                                               input logic [mlpid_pkg::LIM_W-1:0] lim);
        pid_result_t res;
        longint e, lk, s, ig, de, acc, u, kp, ki, kd, lm;
        res.drive   = '0;
        res.clamped = 1'b0;
        if (ch >= CHANNELS)
            return res;
        e  = err;
        lk = (leak_in > mlpid_pkg::ONE_Q15) ? longint'(mlpid_pkg::ONE_Q15)
                                            : longint'(leak_in);
        kp = gains_shadow[ch][47:32];
        ki = gains_shadow[ch][31:16];
        kd = gains_shadow[ch][15:0];
        // leaky integral, rounded half up back to Q24.8
        s  = clip32(longint'(integral_shadow[ch]) + e);
        ig = clip32((s * lk + 64'sd16384) >>> 15);
        integral_shadow[ch] = int'(ig);
        de = e - longint'(last_error_shadow[ch]);
        last_error_shadow[ch] = err;
        acc = kp * e + ki * ig + kd * de;
        u   = (acc + 64'sd2048) >>> 12;
        lm  = lim;
        if (u > lm) begin
            u = lm;
            res.clamped = 1'b1;
        end else if (u < -lm) begin
            u = -lm;
            res.clamped = 1'b1;
        end
        res.drive = u[mlpid_pkg::ERR_W-1:0];
        return res;
    endfunction

    // One input transfer, with an optional random gap before it
    task automatic send_item(input logic [mlpid_pkg::CH_IN_W-1:0] ch,
                             input logic signed [mlpid_pkg::ERR_W-1:0] err,
                             input logic [mlpid_pkg::LEAK_W-1:0] leak_in,
                             input logic [mlpid_pkg::LIM_W-1:0] lim);
        int gap;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_channel  = ch;
        s_error_in = err;
        s_leak     = leak_in;
        s_limit    = lim;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        drive_expect_q.push_back(pid_update(ch, err, leak_in, lim));
    endtask

    // Stop sending and wait for every pending result plus the pipeline tail
    task automatic wait_results_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (drive_expect_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [mlpid_pkg::IDX_W-1:0] idx,
                             input logic [mlpid_pkg::GAIN_W-1:0] value);
        @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        if (idx < mlpid_pkg::GAIN_REGS)
            gains_shadow[idx] = value;
        @(negedge aclk);
        cfg_wen = 1'b0;
    endtask

    function automatic logic [mlpid_pkg::GAIN_W-1:0] random_gains();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return {GAIN_MAX, GAIN_MAX, GAIN_MAX};
            2:       return {16'($urandom), 16'($urandom), 16'($urandom)};
            default: return {16'($urandom_range(0, 16'h2000)), 16'($urandom_range(0, 16'h0400)),
                             16'($urandom_range(0, 16'h2000))};
        endcase
    endfunction

    task automatic send_random_item();
        logic [mlpid_pkg::CH_IN_W-1:0]      ch;
        logic signed [mlpid_pkg::ERR_W-1:0] err;
        logic [mlpid_pkg::LEAK_W-1:0]       lk;
        logic [mlpid_pkg::LIM_W-1:0]        lim;
        ch  = ($urandom_range(0, 11) == 0)
            ? mlpid_pkg::CH_IN_W'($urandom_range(CHANNELS, 7))
            : mlpid_pkg::CH_IN_W'($urandom_range(0, CHANNELS - 1));
        err = ($urandom_range(0, 2) == 0)
            ? mlpid_pkg::ERR_W'($urandom)
            : mlpid_pkg::ERR_W'($urandom_range(0, 1023) - 512);
        lk  = ($urandom_range(0, 3) == 0)
            ? mlpid_pkg::LEAK_W'($urandom)
            : mlpid_pkg::LEAK_W'($urandom_range(28000, 32768));
        case ($urandom_range(0, 5))
            0:       lim = '0;
            1:       lim = mlpid_pkg::LIM_W'($urandom);
            2:       lim = {mlpid_pkg::LIM_W{1'b1}};
            default: lim = mlpid_pkg::LIM_W'($urandom_range(0, 4000));
        endcase
        send_item(ch, err, lk, lim);
    endtask

    // Zero gains after reset: every output is zero whatever the error
    task automatic test_after_reset();
        send_item(3'd0, 16'sh7FFF, 16'd32768, 15'h7FFF);
        send_item(3'd5, -16'sh8000, 16'd32768, 15'h7FFF);
        wait_results_drained();
    endtask

    // Extremes of every field, each gain alone, unused registers, out-of-range channels
    task automatic test_directed();
        write_reg(REG_GAINS_CH0, {GAIN_ONE, 16'h0000, 16'h0000});
        write_reg(REG_GAINS_CH1, {GAIN_MAX, GAIN_MAX, GAIN_MAX});
        write_reg(REG_GAINS_CH2, {16'h0000, 16'h0000, GAIN_ONE});
        write_reg(REG_GAINS_CH3, {16'h0000, GAIN_ONE, 16'h0000});
        write_reg(REG_GAINS_CH4, {16'h0800, 16'h0100, 16'h0400});
        write_reg(REG_GAINS_CH5, '0);
        // writes above the last gain register must not disturb anything
        write_reg(REG_UNUSED_6, {mlpid_pkg::GAIN_W{1'b1}});
        write_reg(REG_UNUSED_7, {mlpid_pkg::GAIN_W{1'b1}});
        send_item(3'd0, 16'sh7FFF, 16'd32768, 15'h7FFF);
        send_item(3'd0, -16'sh8000, 16'd32768, 15'h7FFF);
        send_item(3'd0, 16'sh0100, 16'd32768, 15'h0080);
        send_item(3'd0, -16'sh0100, 16'd32768, 15'h0080);
        // zero limit: output pinned to zero, flagged unless u is zero
        send_item(3'd1, 16'sh7FFF, 16'd32768, 15'h0000);
        send_item(3'd5, 16'sh0000, 16'd32768, 15'h0000);
        send_item(3'd1, -16'sh8000, 16'd0, 15'h7FFF);
        // derivative swings across the full range
        send_item(3'd2, -16'sh8000, 16'd32768, 15'h7FFF);
        send_item(3'd2, 16'sh7FFF, 16'd32768, 15'h7FFF);
        send_item(3'd2, -16'sh8000, 16'd32768, 15'h7FFF);
        // leak above one behaves as one; leak of zero empties the integral
        send_item(3'd3, 16'sh4000, 16'hFFFF, 15'h7FFF);
        send_item(3'd3, 16'sh4000, 16'd32769, 15'h7FFF);
        send_item(3'd3, 16'sh4000, 16'd0, 15'h7FFF);
        send_item(3'd3, -16'sh0001, 16'd1, 15'h7FFF);
        // out-of-range channels give zero and leave state alone
        send_item(3'd6, 16'sh7FFF, 16'hFFFF, 15'h7FFF);
        send_item(3'd7, -16'sh8000, 16'h5555, 15'h2AAA);
        send_item(3'd4, 16'sh0001, 16'd32768, 15'h0001);
        send_item(3'd4, -16'sh0155, 16'h2AAA, 15'h5555);
        send_item(3'd4, 16'sh2AAA, 16'h5555, 15'h2AAA);
        wait_results_drained();
    endtask

    // Random traffic in phases, each with fresh gains; the last phase runs without idling
    task automatic test_random_phases();
        for (int phase = 0; phase < 5; phase++) begin
            for (int ch = 0; ch < CHANNELS; ch++)
                write_reg(REG_GAINS_CH0 + mlpid_pkg::IDX_W'(ch), random_gains());
            if (phase == 4)
                idle_on = 1'b0;
            for (int n = 0; n < 170; n++) begin
                // in the second phase the sender holds off once mid-phase until all results are back
                if (phase == 1 && n == 85)
                    wait_results_drained();
                send_random_item();
            end
            wait_results_drained();
        end
    endtask

    // Push two integrals toward opposite bounds with a leak of one, then leak the large sums
    task automatic test_integral_growth();
        write_reg(REG_GAINS_CH4, {16'h0001, 16'h0001, 16'h0001});
        write_reg(REG_GAINS_CH5, {16'h0001, 16'h0001, 16'h0001});
        for (int n = 0; n < 40; n++)
            send_item(3'd4, 16'sh7FFF, 16'd32768, 15'h7FFF);
        for (int n = 0; n < 40; n++)
            send_item(3'd5, -16'sh8000, 16'd32768, 15'h7FFF);
        for (int n = 0; n < 8; n++) begin
            send_item(3'd4, 16'sh7FFF, 16'($urandom_range(32000, 65535)), 15'h7FFF);
            send_item(3'd5, -16'sh8000, 16'($urandom_range(32000, 65535)), 15'h7FFF);
        end
        wait_results_drained();
    endtask

    // Result side: random stall bursts while idling is enabled
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            m_ready = 1'b0;
            stall_left = $urandom_range(0, 18);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        pid_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_expect_q.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("unexpected result: drive %0d clamped %0d", m_drive, m_clamped);
            end else begin
                want = drive_expect_q.pop_front();
                if (m_drive !== want.drive || m_clamped !== want.clamped) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("mismatch: drive exp %0d got %0d, clamped exp %0d got %0d",
                                 want.drive, m_drive, want.clamped, m_clamped);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_after_reset();
        test_directed();
        test_random_phases();
        test_integral_growth();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && drive_expect_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
